// File: rtl/ema_pkg.sv
// ----------------------------------------------------------------------------
// ema_pkg
// Shared types, register codes and helper functions for the multi-width
// exponential moving average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ema_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OUT_W   = 33;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned ADDR_W  = 4;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]  filtered_t;

  // Data width and signedness of the running average
  typedef enum logic [1:0] {
    MODE_U16 = 2'd0,
    MODE_S16 = 2'd1,
    MODE_U32 = 2'd2,
    MODE_S32 = 2'd3
  } mode_t;

  // Register indexes (word address bits [3:2])
  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_GAIN  = 2'd1,
    REG_SHIFT = 2'd2,
    REG_INIT  = 2'd3
  } reg_idx_t;

  localparam mode_t              RST_MODE  = MODE_S32;
  localparam logic [GAIN_W-1:0]  RST_GAIN  = 16'd1;
  localparam logic [SHIFT_W-1:0] RST_SHIFT = 6'd4;
  localparam logic [DATA_W-1:0]  RST_INIT  = 32'd0;

  // Current register contents
  typedef struct packed {
    mode_t              mode;
    logic [GAIN_W-1:0]  gain;
    logic [SHIFT_W-1:0] shift;
    logic [DATA_W-1:0]  init;
  } cfg_t;

  // Reload request raised on every register write
  typedef struct packed {
    logic              load;
    logic [DATA_W-1:0] value;
  } reload_t;

  // Keep only the bits that count in the given mode
  function automatic logic [DATA_W-1:0] trunc_mode(mode_t m, logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = m[1] ? v : {16'd0, v[15:0]};
    return r;
  endfunction

  // Read v in the mode's width and signedness, widened to 33 bits
  function automatic logic signed [OUT_W-1:0] as_mode(mode_t m, logic [DATA_W-1:0] v);
    logic top_bit;
    logic [OUT_W-1:0] r;
    top_bit = m[0] & (m[1] ? v[31] : v[15]);
    r = m[1] ? {top_bit, v} : {{17{top_bit}}, v[15:0]};
    return $signed(r);
  endfunction

endpackage

`default_nettype wire

// File: rtl/ema_chan_if.sv
// ----------------------------------------------------------------------------
// ema_chan_if
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ema_in_if;
  logic             valid;
  logic             ready;
  ema_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ema_out_if;
  logic               valid;
  logic               ready;
  ema_pkg::filtered_t filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

// File: rtl/ema_filter_multi_width.sv
// ----------------------------------------------------------------------------
// ema_filter_multi_width
// Exponential moving average filter, 16/32-bit, signed or unsigned.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is not stalled and gives one
// filtered word per sample, passed from the input register through the
// result register. The rate is set by the update loop through the average
// register: subtract, a 34 x 17 multiply, a barrel shift and a 32-bit add.
// An input register and a result register decouple the two channels, so a
// sample is taken while a result still waits. Any register write reloads the
// average from the initial value; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ema_filter_multi_width (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  ema_in_if.sink                           in_ch,
  ema_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ema_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  ema_pkg::cfg_t       cfg;
  ema_pkg::reload_t    reload;

  logic                              s1_valid_r;
  logic                              s1_valid_nxt;
  logic [ema_pkg::DATA_W-1:0]        s1_sample_r;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  ema_pkg::filtered_t                out_filtered_r;
  logic [ema_pkg::DATA_W-1:0]        avg_r;
  logic [ema_pkg::DATA_W-1:0]        avg_nxt;
  logic [ema_pkg::DATA_W-1:0]        upd_avg;
  ema_pkg::filtered_t                upd_filtered;
  logic                              s1_adv;
  logic                              in_acc;

  ema_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .reload  (reload)
  );

  ema_upd u_upd (
    .mode     (cfg.mode),
    .gain     (cfg.gain),
    .shift    (cfg.shift),
    .sample   (s1_sample_r),
    .avg      (avg_r),
    .avg_nxt  (upd_avg),
    .filtered (upd_filtered)
  );

  // Handshake: stage moves on when the result register is free or draining
  assign s1_adv      = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~s1_valid_r | s1_adv;
  assign in_acc      = in_ch.valid & in_ch.ready;

  always_comb begin
    s1_valid_nxt  = in_acc | (s1_valid_r & ~s1_adv);
    out_valid_nxt = s1_adv | (out_valid_r & ~out_ch.ready);
  end

  // Running average: register write reloads, otherwise each update lands
  always_comb begin
    priority if (reload.load) begin
      avg_nxt = reload.value;
    end else if (s1_adv) begin
      avg_nxt = upd_avg;
    end else begin
      avg_nxt = avg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      avg_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      avg_r       <= avg_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_ch.sample;
    end
    if (s1_adv) begin
      out_filtered_r <= upd_filtered;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = out_filtered_r;

  // Assertions
  a_adv_fills_out: assert property (
    @(posedge clk) disable iff (!rst_n) s1_adv |=> out_valid_r
  ) else $error("update did not reach the result register");

  a_narrow_upper_zero: assert property (
    @(posedge clk) disable iff (!rst_n) !cfg.mode[1] |-> (avg_r[31:16] == 16'd0)
  ) else $error("upper average bits set in a 16-bit mode");

  a_reload_value: assert property (
    @(posedge clk) disable iff (!rst_n)
      (rst_n && reload.load) |=> (avg_r == $past(reload.value))
  ) else $error("average not reloaded after register write");

  a_free_when_empty: assert property (
    @(posedge clk) disable iff (!rst_n) !out_valid_r |-> in_ch.ready
  ) else $error("input stalled with an empty result register");

endmodule

`default_nettype wire

// File: rtl/ema_cfg.sv
// ----------------------------------------------------------------------------
// ema_cfg
// APB register file: mode, gain, shift and initial value. Every write also
// requests a reload of the running average from the initial value.
// ----------------------------------------------------------------------------
`default_nettype none

module ema_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ema_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output ema_pkg::cfg_t                    cfg,
  output ema_pkg::reload_t                 reload
);

  ema_pkg::cfg_t     cfg_r;
  ema_pkg::cfg_t     cfg_nxt;
  ema_pkg::reg_idx_t idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = ema_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;

  // Next register values
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        ema_pkg::REG_MODE:  cfg_nxt.mode  = ema_pkg::mode_t'(pwdata[1:0]);
        ema_pkg::REG_GAIN:  cfg_nxt.gain  = pwdata[ema_pkg::GAIN_W-1:0];
        ema_pkg::REG_SHIFT: cfg_nxt.shift = pwdata[ema_pkg::SHIFT_W-1:0];
        ema_pkg::REG_INIT:  cfg_nxt.init  = pwdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= ema_pkg::RST_MODE;
      cfg_r.gain  <= ema_pkg::RST_GAIN;
      cfg_r.shift <= ema_pkg::RST_SHIFT;
      cfg_r.init  <= ema_pkg::RST_INIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Reload uses the values as they stand after this write
  assign reload.load  = wr;
  assign reload.value = ema_pkg::trunc_mode(cfg_nxt.mode, cfg_nxt.init);
  assign cfg          = cfg_r;

  // Read-back
  always_comb begin
    unique case (idx)
      ema_pkg::REG_MODE:  prdata = {30'd0, cfg_r.mode};
      ema_pkg::REG_GAIN:  prdata = {16'd0, cfg_r.gain};
      ema_pkg::REG_SHIFT: prdata = {26'd0, cfg_r.shift};
      ema_pkg::REG_INIT:  prdata = cfg_r.init;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/ema_upd.sv
// ----------------------------------------------------------------------------
// ema_upd
// One average update: error in mode width, scale by gain, arithmetic shift,
// wrapping add back into the average.
// ----------------------------------------------------------------------------
`default_nettype none

module ema_upd (
  input  wire ema_pkg::mode_t                      mode,
  input  wire logic [ema_pkg::GAIN_W-1:0]          gain,
  input  wire logic [ema_pkg::SHIFT_W-1:0]         shift,
  input  wire logic [ema_pkg::DATA_W-1:0]          sample,
  input  wire logic [ema_pkg::DATA_W-1:0]          avg,
  output logic [ema_pkg::DATA_W-1:0]               avg_nxt,
  output ema_pkg::filtered_t                       filtered
);

  logic signed [32:0] smp_v;
  logic signed [32:0] avg_v;
  logic signed [33:0] err;
  logic signed [50:0] prod;
  logic signed [50:0] scaled;
  logic        [31:0] sum;

  always_comb begin
    smp_v  = ema_pkg::as_mode(mode, sample);
    avg_v  = ema_pkg::as_mode(mode, avg);
    // 34 bits hold the full difference of two 33-bit values
    err    = $signed({smp_v[32], smp_v}) - $signed({avg_v[32], avg_v});
    // both operands sign-extended to the product width
    prod   = 51'(err) * 51'($signed({1'b0, gain}));
    // floor shift on the exact product
    scaled = prod >>> shift;
    sum    = avg + scaled[31:0];
    avg_nxt  = ema_pkg::trunc_mode(mode, sum);
    filtered = ema_pkg::as_mode(mode, avg_nxt);
  end

endmodule

`default_nettype wire
